// ----- hw/rtl/ffgs_pkg.sv -----
// Shared types, cell and command codes, and the cell update rule of the forest grid.
package ffgs_pkg;

  // Field widths fixed by the interface
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 10;
  localparam int CELL_W  = 2;
  localparam int CFG_W   = 6;

  // Default grid capacity and side length after reset
  localparam int MAX_SIDE_DEF = 32;
  localparam int RESET_SIDE   = 8;

  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [CFG_W-1:0]   cfg_t;

  // 3x3 neighbourhood, [row][column], centre at [1][1]
  typedef logic [2:0][2:0][CELL_W-1:0] win_t;

  localparam cell_t CELL_GROUND = 2'd0;
  localparam cell_t CELL_TREE   = 2'd1;
  localparam cell_t CELL_FIRE   = 2'd2;

  localparam cmd_t CMD_WRITE   = 2'd0;
  localparam cmd_t CMD_ADVANCE = 2'd1;
  localparam cmd_t CMD_READ    = 2'd2;
  localparam cmd_t CMD_NONE    = 2'd3;

  // One generation for the centre cell; cells outside the grid arrive as ground
  function automatic cell_t evolve(win_t w);
    logic       burn;
    logic [7:0] trees;
    cell_t      res;
    burn  = (w[0][1] == CELL_FIRE) || (w[2][1] == CELL_FIRE) ||
            (w[1][0] == CELL_FIRE) || (w[1][2] == CELL_FIRE);
    trees = {w[0][0] == CELL_TREE, w[0][1] == CELL_TREE, w[0][2] == CELL_TREE,
             w[1][0] == CELL_TREE, w[1][2] == CELL_TREE,
             w[2][0] == CELL_TREE, w[2][1] == CELL_TREE, w[2][2] == CELL_TREE};
    if (w[1][1] == CELL_FIRE) begin
      res = CELL_GROUND;
    end else if (w[1][1] == CELL_TREE) begin
      res = burn ? CELL_FIRE : CELL_TREE;
    end else begin
      res = ($countones(trees) > 1) ? CELL_TREE : CELL_GROUND;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/forest_fire_grid_step.sv -----
// Forest fire grid: cell store, read/write commands and a sequenced generation step.
//
//  channel | ports                                              | transaction
//  --------+----------------------------------------------------+---------------------------
//  input   | start, busy, in_command, in_cell_index, in_cell_value | start high, busy low
//  result  | out_valid, out_read_value, out_done_command        | out_valid, one cycle
//  config  | cfg_wr_en, cfg_grid_size                           | cfg_wr_en high
//
//  Write and unused commands finish in idle, a read via ST_READ (registered memory read).
//  An advance on side n > 1 runs a scan where the single grid read port loads one 3x3
//  window column in three reads plus an update slot, then a copy of the new generation
//  through the next-cell port, one cell a cycle. On a 1x1 grid an advance answers
//  straight from the idle state. Reset is synchronous and active low and clears control
//  state only; the receiver cannot stall, busy falls with the strobe.
module forest_fire_grid_step #(
  parameter int MAX_SIDE = ffgs_pkg::MAX_SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ffgs_pkg::cmd_t   in_command,
  input  ffgs_pkg::index_t in_cell_index,
  input  ffgs_pkg::cell_t  in_cell_value,
  output logic             out_valid,
  output ffgs_pkg::cell_t  out_read_value,
  output ffgs_pkg::cmd_t   out_done_command,
  input  logic             cfg_wr_en,
  input  ffgs_pkg::cfg_t   cfg_grid_size
);
  import ffgs_pkg::*;

  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int SW       = $clog2(MAX_SIDE + 1);
  localparam int RST_SIDE = (RESET_SIDE > MAX_SIDE) ? MAX_SIDE : RESET_SIDE;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_COPY = 4'b1000
  } state_t;

  // Cell stores
  cell_t grid_cells_r [DEPTH];
  cell_t next_cells_r [DEPTH];
  cell_t grid_q_r, next_q_r;

  state_t        state_r, state_nxt;
  logic [SW-1:0] side_r, side_nxt;
  logic [CW-1:0] area_r, area_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic [SW-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [AW-1:0] base_r, base_nxt, ctr_r, ctr_nxt;
  logic          eval_r, eval_nxt, last_r, last_nxt;
  win_t          win_r, win_nxt;
  cell_t         cap0_r, cap0_nxt, cap1_r, cap1_nxt;
  logic [AW-1:0] cp_i_r, cp_i_nxt, cp_wa_r, cp_wa_nxt;
  logic          cp_on_r, cp_on_nxt, cp_pend_r, cp_pend_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  cell_t         out_rv_r, out_rv_nxt;
  cmd_t          out_cmd_r, out_cmd_nxt;

  // Memory port controls
  logic          g_we, n_we;
  logic [AW-1:0] g_wa, g_ra, n_wa, scan_addr, row_off;
  cell_t         g_wd, n_wd, fresh;

  logic in_range, col_ok;

  assign in_range = int'(in_cell_index) < int'(area_r);
  assign col_ok   = (col_r != side_r);

  // Row offset of the read issued in this sub-step: row above, same row, row below
  always_comb begin
    case (sub_r)
      2'd0:    row_off = AW'(0) - AW'(side_r);
      2'd2:    row_off = AW'(side_r);
      default: row_off = '0;
    endcase
  end
  assign scan_addr = base_r + row_off + AW'(col_r);
  assign g_ra      = (state_r == ST_IDLE) ? AW'(in_cell_index) : scan_addr;

  // Grid store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_cells_r[g_wa] <= g_wd;
    end
    grid_q_r <= grid_cells_r[g_ra];
  end

  // Next-generation store: written by the scan, read by the copy
  always_ff @(posedge clk) begin
    if (n_we) begin
      next_cells_r[n_wa] <= n_wd;
    end
    next_q_r <= next_cells_r[cp_i_r];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    side_nxt      = side_r;
    area_nxt      = area_r;
    sub_nxt       = sub_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    ctr_nxt       = ctr_r;
    eval_nxt      = eval_r;
    last_nxt      = last_r;
    win_nxt       = win_r;
    cap0_nxt      = cap0_r;
    cap1_nxt      = cap1_r;
    cp_i_nxt      = cp_i_r;
    cp_wa_nxt     = cp_wa_r;
    cp_on_nxt     = cp_on_r;
    cp_pend_nxt   = cp_pend_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_rv_nxt    = out_rv_r;
    out_cmd_nxt   = out_cmd_r;
    g_we          = 1'b0;
    g_wa          = AW'(in_cell_index);
    g_wd          = in_cell_value;
    n_we          = 1'b0;
    n_wa          = ctr_r;
    n_wd          = evolve(win_r);
    fresh         = CELL_GROUND;

    // Grid side register, clamped to 1..MAX_SIDE
    if (cfg_wr_en) begin
      if (cfg_grid_size == '0) begin
        side_nxt = SW'(1);
      end else if (int'(cfg_grid_size) > MAX_SIDE) begin
        side_nxt = SW'(MAX_SIDE);
      end else begin
        side_nxt = SW'(cfg_grid_size);
      end
      area_nxt = CW'(side_nxt) * CW'(side_nxt);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_cmd_nxt = in_command;
          out_rv_nxt  = CELL_GROUND;
          unique case (in_command)
            CMD_WRITE: begin
              g_we          = in_range;
              out_valid_nxt = 1'b1;
            end
            CMD_READ: begin
              rd_ok_nxt = in_range;
              state_nxt = ST_READ;
            end
            CMD_ADVANCE: begin
              if (side_r == SW'(1)) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_SCAN;
                sub_nxt   = 2'd0;
                row_nxt   = '0;
                col_nxt   = '0;
                base_nxt  = '0;
                ctr_nxt   = '0;
                eval_nxt  = 1'b0;
                last_nxt  = 1'b0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_rv_nxt    = rd_ok_r ? grid_q_r : CELL_GROUND;
        state_nxt     = ST_IDLE;
      end

      ST_SCAN: begin
        unique case (sub_r)
          2'd0: begin
            // update slot for the centre cell, and the read of the row above
            if (eval_r) begin
              n_we     = 1'b1;
              ctr_nxt  = ctr_r + AW'(1);
              eval_nxt = 1'b0;
            end
            if (last_r) begin
              state_nxt   = ST_COPY;
              cp_i_nxt    = '0;
              cp_on_nxt   = 1'b1;
              cp_pend_nxt = 1'b0;
            end else begin
              sub_nxt = 2'd1;
            end
          end
          2'd1: begin
            cap0_nxt = (row_r != '0 && col_ok) ? grid_q_r : CELL_GROUND;
            sub_nxt  = 2'd2;
          end
          2'd2: begin
            cap1_nxt = col_ok ? grid_q_r : CELL_GROUND;
            sub_nxt  = 2'd3;
          end
          default: begin
            // shift the window left and take in the new column
            fresh = (row_r != side_r - SW'(1) && col_ok) ? grid_q_r : CELL_GROUND;
            for (int k = 0; k < 3; k++) begin
              win_nxt[k][0] = win_r[k][1];
              win_nxt[k][1] = (col_r == '0) ? CELL_GROUND : win_r[k][2];
            end
            win_nxt[0][2] = cap0_r;
            win_nxt[1][2] = cap1_r;
            win_nxt[2][2] = fresh;
            eval_nxt      = (col_r != '0);
            if (col_r == side_r) begin
              col_nxt  = '0;
              row_nxt  = row_r + SW'(1);
              base_nxt = base_r + AW'(side_r);
              last_nxt = (row_r == side_r - SW'(1));
            end else begin
              col_nxt = col_r + SW'(1);
            end
            sub_nxt = 2'd0;
          end
        endcase
      end

      ST_COPY: begin
        // read next cell i, write it into the grid in the following cycle
        if (cp_on_r) begin
          cp_pend_nxt = 1'b1;
          cp_wa_nxt   = cp_i_r;
          if (CW'(cp_i_r) == area_r - CW'(1)) begin
            cp_on_nxt = 1'b0;
          end else begin
            cp_i_nxt = cp_i_r + AW'(1);
          end
        end else begin
          cp_pend_nxt = 1'b0;
        end
        if (cp_pend_r) begin
          g_we = 1'b1;
          g_wa = cp_wa_r;
          g_wd = next_q_r;
          if (CW'(cp_wa_r) == area_r - CW'(1)) begin
            out_valid_nxt = 1'b1;
            out_rv_nxt    = CELL_GROUND;
            out_cmd_nxt   = CMD_ADVANCE;
            cp_pend_nxt   = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      side_r      <= SW'(RST_SIDE);
      area_r      <= CW'(RST_SIDE * RST_SIDE);
      sub_r       <= '0;
      eval_r      <= 1'b0;
      last_r      <= 1'b0;
      cp_on_r     <= 1'b0;
      cp_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      area_r      <= area_nxt;
      sub_r       <= sub_nxt;
      eval_r      <= eval_nxt;
      last_r      <= last_nxt;
      cp_on_r     <= cp_on_nxt;
      cp_pend_r   <= cp_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    base_r    <= base_nxt;
    ctr_r     <= ctr_nxt;
    win_r     <= win_nxt;
    cap0_r    <= cap0_nxt;
    cap1_r    <= cap1_nxt;
    cp_i_r    <= cp_i_nxt;
    cp_wa_r   <= cp_wa_nxt;
    rd_ok_r   <= rd_ok_nxt;
    out_rv_r  <= out_rv_nxt;
    out_cmd_r <= out_cmd_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_read_value   = out_rv_r;
  assign out_done_command = out_cmd_r;

endmodule
